/* hw/rtl/bics_pkg.sv */
`default_nettype none

package bics_pkg;

	localparam int unsigned OP_W   = 3;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned SUM_W  = 16;
	localparam int unsigned CNT_W  = 16;
	localparam int unsigned FBC_W  = 3;
	localparam int unsigned ST_W   = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [OP_W-1:0] OP_START  = 3'd0;
	localparam logic [OP_W-1:0] OP_IMAGE  = 3'd1;
	localparam logic [OP_W-1:0] OP_DEVICE = 3'd2;
	localparam logic [OP_W-1:0] OP_END    = 3'd3;
	localparam logic [OP_W-1:0] OP_TMO    = 3'd4;

	localparam logic [ST_W-1:0] ST_BUSY    = 3'd0;
	localparam logic [ST_W-1:0] ST_DONE    = 3'd1;
	localparam logic [ST_W-1:0] ST_FORMAT  = 3'd2;
	localparam logic [ST_W-1:0] ST_XFER    = 3'd3;
	localparam logic [ST_W-1:0] ST_IGNORED = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HDR_LEN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACK      = 2'd2;

	localparam logic [CNT_W-1:0]  INTERVAL_RST = 16'h0080;
	localparam logic [BYTE_W-1:0] HDR_LEN_RST  = 8'd22;
	localparam logic [BYTE_W-1:0] ACK_RST      = 8'h2D;

	localparam logic [FBC_W-1:0] ADDR_BYTES = 3'd4;

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_HEADER = 7'b0000010,
		PH_SIZE   = 7'b0000100,
		PH_ADDR   = 7'b0001000,
		PH_WORDS  = 7'b0010000,
		PH_CKLO   = 7'b0100000,
		PH_CKHI   = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [CNT_W-1:0]  interval;
		logic [BYTE_W-1:0] hdr_len;
		logic [BYTE_W-1:0] ack;
	} cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic [SUM_W-1:0]  byte_sum;
		logic [BYTE_W-1:0] header_count;
		logic [CNT_W-1:0]  block_words;
		logic [CNT_W-1:0]  words_sent;
		logic [CNT_W-1:0]  since_hs;
		logic [FBC_W-1:0]  fbc;
		logic [BYTE_W-1:0] received_low;
		logic              ret_words;
	} sess_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] data_byte;
	} item_t;

	typedef struct packed {
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_byte;
		logic [ST_W-1:0]   status;
		logic              expect_device;
		logic [SUM_W-1:0]  running_sum;
	} res_t;

	localparam sess_t SESS_RST = '{
		phase:        PH_IDLE,
		byte_sum:     '0,
		header_count: '0,
		block_words:  '0,
		words_sent:   '0,
		since_hs:     '0,
		fbc:          '0,
		received_low: '0,
		ret_words:    1'b0
	};

endpackage

`default_nettype wire

/* hw/rtl/bics_if.sv */
`default_nettype none

interface bics_in_if;
	logic                         valid;
	logic                         ready;
	logic [bics_pkg::OP_W-1:0]    op;
	logic [bics_pkg::BYTE_W-1:0]  data_byte;

	modport source (output valid, output op, output data_byte, input ready);
	modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface bics_out_if;
	logic                         valid;
	logic                         ready;
	logic                         tx_valid;
	logic [bics_pkg::BYTE_W-1:0]  tx_byte;
	logic [bics_pkg::ST_W-1:0]    status;
	logic                         expect_device;
	logic [bics_pkg::SUM_W-1:0]   running_sum;

	modport source (output valid, output tx_valid, output tx_byte, output status,
		output expect_device, output running_sum, input ready);
	modport sink   (input valid, input tx_valid, input tx_byte, input status,
		input expect_device, input running_sum, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bics_in_stage.sv */
`default_nettype none

module bics_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	bics_in_if.sink            in_ch,
	input  wire logic          take,
	output bics_pkg::item_t    item_s1,
	output logic               valid_s1
);

	assign in_ch.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.op        <= in_ch.op;
			item_s1.data_byte <= in_ch.data_byte;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/bics_step.sv */
`default_nettype none

module bics_step (
	input  wire bics_pkg::item_t   item,
	input  wire bics_pkg::cfg_t    cfg,
	input  wire bics_pkg::sess_t   cur,
	output bics_pkg::sess_t   nxt,
	output bics_pkg::res_t    res
);

	logic                          want_dev;
	logic                          want_img;
	logic [bics_pkg::BYTE_W-1:0]   hc_inc;
	logic [bics_pkg::CNT_W-1:0]    bw_full;
	logic [bics_pkg::FBC_W-1:0]    fbc_inc;
	logic [bics_pkg::CNT_W-1:0]    ws_inc;
	logic [bics_pkg::CNT_W-1:0]    sh_inc;
	logic [bics_pkg::SUM_W-1:0]    got;
	logic [bics_pkg::SUM_W-1:0]    sum_add;

	always_comb begin
		want_dev = (cur.phase == bics_pkg::PH_CKLO) || (cur.phase == bics_pkg::PH_CKHI);
		want_img = (cur.phase == bics_pkg::PH_HEADER) || (cur.phase == bics_pkg::PH_SIZE)
			|| (cur.phase == bics_pkg::PH_ADDR) || (cur.phase == bics_pkg::PH_WORDS);
		hc_inc   = cur.header_count + 8'd1;
		bw_full  = cur.block_words | {item.data_byte, 8'd0};
		fbc_inc  = cur.fbc + 3'd1;
		ws_inc   = cur.words_sent + 16'd1;
		sh_inc   = cur.since_hs + 16'd1;
		got      = {item.data_byte, cur.received_low};
		sum_add  = cur.byte_sum + {8'd0, item.data_byte};

		nxt = cur;
		res.tx_valid = 1'b0;
		res.tx_byte  = '0;
		res.status   = bics_pkg::ST_BUSY;

		if (item.op == bics_pkg::OP_START) begin
			nxt = bics_pkg::SESS_RST;
			nxt.phase = bics_pkg::PH_HEADER;
		end else if (item.op == bics_pkg::OP_IMAGE && want_img) begin
			res.tx_valid = 1'b1;
			res.tx_byte  = item.data_byte;
			nxt.byte_sum = sum_add;
			unique case (cur.phase)
				bics_pkg::PH_HEADER: begin
					nxt.header_count = hc_inc;
					if (hc_inc == cfg.hdr_len) begin
						nxt.fbc       = '0;
						nxt.ret_words = 1'b0;
						nxt.phase     = bics_pkg::PH_CKLO;
					end
				end
				bics_pkg::PH_SIZE: begin
					if (cur.fbc == '0) begin
						nxt.block_words = {8'd0, item.data_byte};
						nxt.fbc         = 3'd1;
					end else begin
						nxt.block_words = bw_full;
						nxt.fbc         = '0;
						if (bw_full == '0) begin
							res.status = bics_pkg::ST_DONE;
							nxt.phase  = bics_pkg::PH_IDLE;
						end else begin
							nxt.phase = bics_pkg::PH_ADDR;
						end
					end
				end
				bics_pkg::PH_ADDR: begin
					nxt.fbc = fbc_inc;
					if (fbc_inc == bics_pkg::ADDR_BYTES) begin
						nxt.fbc        = '0;
						nxt.words_sent = '0;
						nxt.since_hs   = '0;
						nxt.phase      = bics_pkg::PH_WORDS;
					end
				end
				default: begin
					if (cur.fbc == '0) begin
						nxt.fbc = 3'd1;
					end else begin
						nxt.fbc        = '0;
						nxt.words_sent = ws_inc;
						nxt.since_hs   = sh_inc;
						if (ws_inc == cur.block_words) begin
							nxt.ret_words = 1'b0;
							nxt.phase     = bics_pkg::PH_CKLO;
						end else if (sh_inc == cfg.interval) begin
							nxt.since_hs  = '0;
							nxt.ret_words = 1'b1;
							nxt.phase     = bics_pkg::PH_CKLO;
						end
					end
				end
			endcase
		end else if (item.op == bics_pkg::OP_DEVICE && want_dev) begin
			res.tx_valid = 1'b1;
			res.tx_byte  = cfg.ack;
			if (cur.phase == bics_pkg::PH_CKLO) begin
				nxt.received_low = item.data_byte;
				nxt.phase        = bics_pkg::PH_CKHI;
			end else if (got != cur.byte_sum) begin
				res.status = bics_pkg::ST_XFER;
				nxt.phase  = bics_pkg::PH_IDLE;
			end else begin
				nxt.phase = cur.ret_words ? bics_pkg::PH_WORDS : bics_pkg::PH_SIZE;
			end
		end else if (item.op == bics_pkg::OP_END && want_img) begin
			res.status = bics_pkg::ST_FORMAT;
			nxt.phase  = bics_pkg::PH_IDLE;
		end else if (item.op == bics_pkg::OP_TMO && want_dev) begin
			res.status = bics_pkg::ST_XFER;
			nxt.phase  = bics_pkg::PH_IDLE;
		end else begin
			res.status = bics_pkg::ST_IGNORED;
		end

		res.expect_device = (nxt.phase == bics_pkg::PH_CKLO)
			|| (nxt.phase == bics_pkg::PH_CKHI);
		res.running_sum   = nxt.byte_sum;
	end

endmodule

`default_nettype wire

/* hw/rtl/bics_out_stage.sv */
`default_nettype none

module bics_out_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire bics_pkg::res_t res,
	output logic               can_load,
	bics_out_if.source         out_ch
);

	bics_pkg::res_t res_q;
	logic           valid_q;

	assign can_load = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_q <= res;
		end
	end

	assign out_ch.valid         = valid_q;
	assign out_ch.tx_valid      = res_q.tx_valid;
	assign out_ch.tx_byte       = res_q.tx_byte;
	assign out_ch.status        = res_q.status;
	assign out_ch.expect_device = res_q.expect_device;
	assign out_ch.running_sum   = res_q.running_sum;

endmodule

`default_nettype wire

/* hw/rtl/boot_image_checksum_sender_top.sv */
// channel   dir   payload                                                    accepted when
// in_ch     in    op[2:0], data_byte[7:0]                                    valid && ready
// out_ch    out   tx_valid, tx_byte[7:0], status[2:0], expect_device, running_sum[15:0]
//                                                                           valid && ready
// cfg       in    cfg_we, cfg_index[1:0], cfg_data[15:0]                     cfg_we high
//
// one request per cycle while no result is held; a taken request is registered in the input
// register, then its result in the result register; the session update for one request is one
// combinational step between the input register and the result register
// arst_n clears the session to idle and the config registers to their defaults
// a held result stalls the step; the input register still takes one request

`default_nettype none

module boot_image_checksum_sender_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [bics_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bics_pkg::CFG_DATA_W-1:0]    cfg_data,
	bics_in_if.sink                                 in_ch,
	bics_out_if.source                              out_ch
);

	bics_pkg::item_t item_s1;
	logic            valid_s1;
	logic            can_load;
	logic            advance;
	bics_pkg::cfg_t  cfg_q;
	bics_pkg::sess_t sess_q;
	bics_pkg::sess_t sess_nxt;
	bics_pkg::res_t  res;

	assign advance = valid_s1 && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval <= bics_pkg::INTERVAL_RST;
			cfg_q.hdr_len  <= bics_pkg::HDR_LEN_RST;
			cfg_q.ack      <= bics_pkg::ACK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bics_pkg::REG_INTERVAL: cfg_q.interval <= cfg_data;
				bics_pkg::REG_HDR_LEN:  cfg_q.hdr_len  <= cfg_data[bics_pkg::BYTE_W-1:0];
				bics_pkg::REG_ACK:      cfg_q.ack      <= cfg_data[bics_pkg::BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sess_q <= bics_pkg::SESS_RST;
		end else if (advance) begin
			sess_q <= sess_nxt;
		end
	end

	bics_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.take     (advance),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1)
	);

	bics_step u_step (
		.item (item_s1),
		.cfg  (cfg_q),
		.cur  (sess_q),
		.nxt  (sess_nxt),
		.res  (res)
	);

	bics_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (valid_s1),
		.res      (res),
		.can_load (can_load),
		.out_ch   (out_ch)
	);

`ifndef SYNTH
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(sess_q.phase))
		else $error("phase not one-hot");

	a_send_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.tx_valid |->
		out_ch.status != bics_pkg::ST_FORMAT && out_ch.status != bics_pkg::ST_IGNORED)
		else $error("byte sent with a non-sending status");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (res.status == bics_pkg::ST_DONE || res.status == bics_pkg::ST_FORMAT
		|| res.status == bics_pkg::ST_XFER) |=> sess_q.phase == bics_pkg::PH_IDLE)
		else $error("session not idle after its end");

	a_expect_match: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_ch.expect_device == ((sess_q.phase == bics_pkg::PH_CKLO)
		|| (sess_q.phase == bics_pkg::PH_CKHI)))
		else $error("expect_device disagrees with phase");
`endif

endmodule

`default_nettype wire
